/* src/matrix_chain_order_dp_core_macros.svh */
// Assertion macros shared by the matrix chain order core.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MATRIX_CHAIN_ORDER_DP_CORE_MACROS_SVH
`define MATRIX_CHAIN_ORDER_DP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MCOD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCOD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCOD_ASSERT(lbl, prop, msg)
`define MCOD_NEVER(lbl, cond, msg)
`endif
`endif

/* src/mcod_pkg.sv */
// Package of the matrix chain order core: sizes, types, state encoding, helpers.
// No dependencies; the interfaces, the top level, the datapath and the controller import it.
package mcod_pkg;

    localparam int MAX_MATRICES = 8;
    localparam int DIM_WIDTH    = 16;

    localparam int SIZE_W     = 16;
    localparam int OUT_IDX_W  = 3;
    localparam int COST_W     = 52;
    localparam int DIM_DEPTH  = MAX_MATRICES + 1;
    localparam int IDX_W      = $clog2(DIM_DEPTH);
    localparam int CNT_W      = $clog2(DIM_DEPTH + 1);
    localparam int COST_DEPTH = MAX_MATRICES * MAX_MATRICES;
    localparam int CADDR_W    = $clog2(COST_DEPTH);
    localparam int PIJ_W      = 2 * DIM_WIDTH;
    localparam int PROD_W     = 3 * DIM_WIDTH;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CADDR_W-1:0]   caddr_t;
    typedef logic [COST_W-1:0]    cost_t;
    typedef logic [OUT_IDX_W-1:0] out_idx_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CELL_A,
        S_CELL_B,
        S_CELL_C,
        S_K_RD,
        S_K_MUL,
        S_K_ADD,
        S_CELL_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_ERR_LD
    } state_t;

    typedef struct packed {
        logic   dim_wr;
        idx_t   dim_wr_addr;
        logic   dim_rd;
        idx_t   dim_rd_addr;
        logic   lat_pi;
        logic   lat_pij;
        logic   cost_rd;
        caddr_t addr_a;
        caddr_t addr_b;
        logic   zero_a;
        logic   zero_b;
        logic   mul_k;
        logic   add_k;
        logic   first_k;
        idx_t   k;
        logic   cost_wr;
        caddr_t wr_addr;
        logic   load_out;
        logic   load_err;
        idx_t   row;
        idx_t   col;
        logic   last;
    } mcod_cmd_t;

    typedef struct packed {
        logic out_free;
    } mcod_stat_t;

    // Flat table address of subchain (i, j).
    function automatic caddr_t cost_addr(input idx_t i, input idx_t j);
        return CADDR_W'(int'(i) * MAX_MATRICES + int'(j));
    endfunction

    // Matrix indices leave the block on three bits.
    function automatic out_idx_t to_out_idx(input idx_t v);
        logic [IDX_W+OUT_IDX_W-1:0] ext;
        ext = {{OUT_IDX_W{1'b0}}, v};
        return ext[OUT_IDX_W-1:0];
    endfunction

endpackage

/* src/mcod_ifs.sv */
// Valid/ready channel interfaces of the matrix chain order core.
// Depends on mcod_pkg for the field widths.
interface mcod_in_if import mcod_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] dim_size;
    logic              last_dim;

    modport source (output valid, output dim_size, output last_dim, input ready);
    modport sink   (input valid, input dim_size, input last_dim, output ready);
endinterface

interface mcod_out_if import mcod_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] row_index;
    logic [OUT_IDX_W-1:0] col_index;
    logic [OUT_IDX_W-1:0] split_point;
    logic [COST_W-1:0]    min_cost;
    logic                 chain_error;
    logic                 last_entry;

    modport source (output valid, output row_index, output col_index, output split_point,
                    output min_cost, output chain_error, output last_entry, input ready);
    modport sink   (input valid, input row_index, input col_index, input split_point,
                    input min_cost, input chain_error, input last_entry, output ready);
endinterface

/* src/matrix_chain_order_dp_core.sv */
// Top level of the matrix chain order core: controller plus datapath.
// Depends on mcod_pkg, mcod_ifs, mcod_controller and mcod_datapath.

// The core takes a chain of matrix dimensions p0..pn, one per transaction on the
// dims channel, the transaction with last_dim set closing the chain. Matrix t is
// p[t] x p[t+1]. For every subchain i..j it finds the minimum number of scalar
// multiplications and the split that reaches it, the smallest split winning a
// tie, and sends the table row by row (i ascending, then j) on the results
// channel, last_entry marking the final transaction. A chain of fewer than two
// matrices, or longer than MAX_MATRICES, gives one transaction with chain_error
// set. Dimensions load at one per cycle. Once the chain is closed the core stops
// taking dimensions: each subchain has set-up and write-back steps plus a read,
// multiply and add step for each candidate split, paced by the single read port
// of the dimension store and the two-step multiply of p[i]*p[j+1] by p[k+1];
// readout then fetches each table entry through the registered table read and
// loads it into the output register, waiting while that register is still full.
// New dimensions are taken again as soon as the final result has been moved
// into the output register.
module matrix_chain_order_dp_core
    import mcod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcod_in_if.sink     dims,
    mcod_out_if.source  results
);

    mcod_cmd_t            cmd;
    mcod_stat_t           stat;
    logic [DIM_WIDTH-1:0] dim_data;

    // Only the low DIM_WIDTH bits of a dimension take part in the arithmetic.
    assign dim_data = dims.dim_size[DIM_WIDTH-1:0];

    mcod_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .dims  (dims),
        .cmd   (cmd),
        .stat  (stat)
    );

    mcod_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .dim_data (dim_data),
        .cmd      (cmd),
        .stat     (stat),
        .results  (results)
    );

endmodule

/* src/mcod_datapath.sv */
// Datapath: dimension store, cost and split tables, multiplier chain, output register.
// Depends on mcod_pkg and mcod_out_if; driven by commands from mcod_controller.
module mcod_datapath
    import mcod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DIM_WIDTH-1:0] dim_data,
    input  mcod_cmd_t            cmd,
    output mcod_stat_t           stat,
    mcod_out_if.source           results
);

    logic [DIM_WIDTH-1:0] dim_mem [DIM_DEPTH];
    logic [DIM_WIDTH-1:0] dim_rdata_reg;
    cost_t                cost_mem [COST_DEPTH];
    idx_t                 split_mem [COST_DEPTH];
    cost_t                ca_reg;
    cost_t                cb_reg;
    idx_t                 sp_reg;

    logic [DIM_WIDTH-1:0] pi_reg;
    logic [PIJ_W-1:0]     pij_reg;
    logic [PROD_W-1:0]    prod_reg;
    cost_t                ab_reg;
    cost_t                best_reg;
    idx_t                 best_k_reg;
    cost_t                cand;

    logic                 out_valid_reg;
    out_idx_t             out_row_reg;
    out_idx_t             out_col_reg;
    out_idx_t             out_split_reg;
    cost_t                out_cost_reg;
    logic                 out_err_reg;
    logic                 out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dim_wr)
        begin
            dim_mem[cmd.dim_wr_addr] <= dim_data;
        end
        if (cmd.dim_rd)
        begin
            dim_rdata_reg <= dim_mem[cmd.dim_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cost_wr)
        begin
            cost_mem[cmd.wr_addr]  <= best_reg;
            split_mem[cmd.wr_addr] <= best_k_reg;
        end
        if (cmd.cost_rd)
        begin
            ca_reg <= cost_mem[cmd.addr_a];
            cb_reg <= cost_mem[cmd.addr_b];
            sp_reg <= split_mem[cmd.addr_a];
        end
    end

    assign cand = ab_reg + COST_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.lat_pi)
        begin
            pi_reg <= dim_rdata_reg;
        end
        if (cmd.lat_pij)
        begin
            pij_reg <= PIJ_W'(pi_reg) * PIJ_W'(dim_rdata_reg);
        end
        if (cmd.mul_k)
        begin
            prod_reg <= PROD_W'(pij_reg) * PROD_W'(dim_rdata_reg);
            ab_reg   <= (cmd.zero_a ? '0 : ca_reg) + (cmd.zero_b ? '0 : cb_reg);
        end
        // Strictly-less keeps the smallest split on a tie.
        if (cmd.add_k && (cmd.first_k || (cand < best_reg)))
        begin
            best_reg   <= cand;
            best_k_reg <= cmd.k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out || cmd.load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_split_reg <= '0;
            out_cost_reg  <= '0;
            out_err_reg   <= 1'b1;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.load_out)
        begin
            out_row_reg   <= to_out_idx(cmd.row);
            out_col_reg   <= to_out_idx(cmd.col);
            out_split_reg <= to_out_idx(sp_reg);
            out_cost_reg  <= ca_reg;
            out_err_reg   <= 1'b0;
            out_last_reg  <= cmd.last;
        end
    end

    assign stat.out_free       = !out_valid_reg || results.ready;
    assign results.valid       = out_valid_reg;
    assign results.row_index   = out_row_reg;
    assign results.col_index   = out_col_reg;
    assign results.split_point = out_split_reg;
    assign results.min_cost    = out_cost_reg;
    assign results.chain_error = out_err_reg;
    assign results.last_entry  = out_last_reg;

endmodule

/* src/mcod_controller.sv */
// Controller: loads the chain, sequences the dynamic program and the table readout.
// Depends on mcod_pkg, mcod_in_if and the assertion macro header.
`include "matrix_chain_order_dp_core_macros.svh"

module mcod_controller
    import mcod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcod_in_if.sink    dims,
    output mcod_cmd_t  cmd,
    input  mcod_stat_t stat
);

    state_t state_reg, state_next;
    cnt_t   dim_count_reg, dim_count_next;
    logic   overflow_reg, overflow_next;
    idx_t   n_reg, n_next;
    idx_t   len_reg, len_next;
    idx_t   i_reg, i_next;
    idx_t   k_reg, k_next;
    idx_t   ei_reg, ei_next;
    idx_t   ej_reg, ej_next;

    idx_t   j;
    idx_t   j1;
    idx_t   k1;
    logic   room;
    cnt_t   count_now;
    logic   emit_last;

    assign j    = i_reg + len_reg;
    assign j1   = j + idx_t'(1);
    assign k1   = k_reg + idx_t'(1);
    assign room = dim_count_reg < cnt_t'(DIM_DEPTH);
    assign count_now = room ? dim_count_reg + cnt_t'(1) : dim_count_reg;
    assign emit_last = (ei_reg == n_reg - idx_t'(2)) && (ej_reg == n_reg - idx_t'(1));

    assign dims.ready = (state_reg == S_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            dim_count_reg <= '0;
            overflow_reg  <= 1'b0;
            n_reg         <= '0;
            len_reg       <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            ei_reg        <= '0;
            ej_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_count_reg <= dim_count_next;
            overflow_reg  <= overflow_next;
            n_reg         <= n_next;
            len_reg       <= len_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            ei_reg        <= ei_next;
            ej_reg        <= ej_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        dim_count_next = dim_count_reg;
        overflow_next  = overflow_reg;
        n_next         = n_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        ei_next        = ei_reg;
        ej_next        = ej_reg;
        cmd            = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (dims.valid)
                begin
                    if (room)
                    begin
                        cmd.dim_wr      = 1'b1;
                        cmd.dim_wr_addr = dim_count_reg[IDX_W-1:0];
                        dim_count_next  = count_now;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (dims.last_dim)
                    begin
                        dim_count_next = '0;
                        overflow_next  = 1'b0;
                        if (overflow_reg || !room || (count_now < cnt_t'(3)))
                        begin
                            state_next = S_ERR_LD;
                        end
                        else
                        begin
                            n_next     = IDX_W'(count_now - cnt_t'(1));
                            len_next   = idx_t'(1);
                            i_next     = '0;
                            state_next = S_CELL_A;
                        end
                    end
                end
            end
            S_CELL_A:
            begin
                cmd.dim_rd      = 1'b1;
                cmd.dim_rd_addr = i_reg;
                state_next      = S_CELL_B;
            end
            S_CELL_B:
            begin
                cmd.lat_pi      = 1'b1;
                cmd.dim_rd      = 1'b1;
                cmd.dim_rd_addr = j1;
                state_next      = S_CELL_C;
            end
            S_CELL_C:
            begin
                cmd.lat_pij = 1'b1;
                k_next      = i_reg;
                state_next  = S_K_RD;
            end
            S_K_RD:
            begin
                cmd.dim_rd      = 1'b1;
                cmd.dim_rd_addr = k1;
                cmd.cost_rd     = 1'b1;
                cmd.addr_a      = cost_addr(i_reg, k_reg);
                cmd.addr_b      = cost_addr(k1, j);
                state_next      = S_K_MUL;
            end
            S_K_MUL:
            begin
                // Diagonal entries are never stored; they read as zero cost.
                cmd.mul_k  = 1'b1;
                cmd.zero_a = (k_reg == i_reg);
                cmd.zero_b = (k1 == j);
                state_next = S_K_ADD;
            end
            S_K_ADD:
            begin
                cmd.add_k   = 1'b1;
                cmd.first_k = (k_reg == i_reg);
                cmd.k       = k_reg;
                if (k1 == j)
                begin
                    state_next = S_CELL_WR;
                end
                else
                begin
                    k_next     = k1;
                    state_next = S_K_RD;
                end
            end
            S_CELL_WR:
            begin
                cmd.cost_wr = 1'b1;
                cmd.wr_addr = cost_addr(i_reg, j);
                if (j1 < n_reg)
                begin
                    i_next     = i_reg + idx_t'(1);
                    state_next = S_CELL_A;
                end
                else if (len_reg + idx_t'(1) < n_reg)
                begin
                    len_next   = len_reg + idx_t'(1);
                    i_next     = '0;
                    state_next = S_CELL_A;
                end
                else
                begin
                    ei_next    = '0;
                    ej_next    = idx_t'(1);
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.cost_rd = 1'b1;
                cmd.addr_a  = cost_addr(ei_reg, ej_reg);
                cmd.addr_b  = cost_addr(ei_reg, ej_reg);
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.row      = ei_reg;
                    cmd.col      = ej_reg;
                    cmd.last     = emit_last;
                    if (emit_last)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        if (ej_reg == n_reg - idx_t'(1))
                        begin
                            ei_next = ei_reg + idx_t'(1);
                            ej_next = ei_reg + idx_t'(2);
                        end
                        else
                        begin
                            ej_next = ej_reg + idx_t'(1);
                        end
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_ERR_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    `MCOD_NEVER(a_count_bound, dim_count_reg > cnt_t'(DIM_DEPTH), "dimension count past store depth")
    `MCOD_ASSERT(a_cell_bound, (state_reg == S_CELL_A) |-> (j < n_reg), "subchain end past chain")
    `MCOD_ASSERT(a_split_bound, (state_reg == S_K_ADD) |-> (k_reg >= i_reg && k_reg < j), "split outside subchain")
    `MCOD_ASSERT(a_cell_next, (state_reg == S_CELL_WR) |=> (state_reg == S_CELL_A || state_reg == S_EMIT_RD), "bad step after table write")
    `MCOD_ASSERT(a_emit_bound, (state_reg == S_EMIT_LD) |-> (ei_reg < ej_reg && ej_reg < n_reg), "readout index out of range")

endmodule
